### rtl/core/ccp_pkg.sv
// Shared types and constants of the class constant-pool parser.
// Used by ccp_parser, ccp_out_fifo and class_constant_pool_parser.
`default_nettype none

package ccp_pkg;

  // Constant-pool tag codes
  localparam logic [7:0] TagUtf8     = 8'd1;
  localparam logic [7:0] TagInteger  = 8'd3;
  localparam logic [7:0] TagFloat    = 8'd4;
  localparam logic [7:0] TagLong     = 8'd5;
  localparam logic [7:0] TagDouble   = 8'd6;
  localparam logic [7:0] TagClass    = 8'd7;
  localparam logic [7:0] TagString   = 8'd8;
  localparam logic [7:0] TagFieldRef = 8'd9;
  localparam logic [7:0] TagMethRef  = 8'd10;
  localparam logic [7:0] TagIfMethRef = 8'd11;
  localparam logic [7:0] TagNameType = 8'd12;

  // Operand byte counts
  localparam logic [2:0] ShortOperandLen = 3'd2;
  localparam logic [2:0] WordOperandLen  = 3'd4;

  // Configuration register indexes
  localparam logic CfgPoolCount = 1'b0;
  localparam logic CfgBaseOffset = 1'b1;

  // Reset values of the configuration registers
  localparam logic [15:0] PoolCountReset  = 16'd1;
  localparam logic [31:0] BaseOffsetReset = 32'd10;

  typedef enum logic [2:0] {
    PhTag    = 3'd0,
    PhOper   = 3'd1,
    PhWideHi = 3'd2,
    PhWideLo = 3'd3,
    PhUlen   = 3'd4,
    PhUskip  = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    StOk         = 2'd0,
    StUnknownTag = 2'd1,
    StWideOvf    = 2'd2
  } status_e;

  typedef struct packed {
    logic [15:0] pool_count;
    logic [31:0] base_offset;
  } cfg_t;

  typedef struct packed {
    logic [15:0] slot_index;
    logic [3:0]  entry_tag;
    logic [31:0] entry_value;
    logic        last_entry;
    status_e     status;
  } res_t;

endpackage

`default_nettype wire

### rtl/core/ccp_parser.sv
// Input register and parser state: one byte item is decoded per cycle while the result buffer is not full.
// Depends on ccp_pkg for phase codes, tag codes and the result struct.
`default_nettype none

module ccp_parser import ccp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_start_i,
  output logic            res_valid_o,
  output res_t            res_o,
  input  wire logic       res_full_i
);

  // Input register
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       start_q;
  logic       advance;

  // Parser state
  logic [15:0] slot_q, slot_d;
  logic [3:0]  tag_q, tag_d;
  phase_e      phase_q, phase_d;
  logic [2:0]  left_q, left_d;
  logic [31:0] acc_q, acc_d;
  logic [15:0] skip_q, skip_d;
  logic [31:0] pos_q, pos_d;
  logic        halt_q, halt_d;

  // State as seen after a restart flag
  logic [15:0] slot_e;
  phase_e      phase_e_v;
  logic [2:0]  left_e;
  logic [15:0] skip_e;
  logic [31:0] pos_e;
  logic        halt_e;

  logic        hit;
  logic        fin;
  logic [15:0] fin_step;
  res_t        res;

  assign advance    = in_valid_q && !res_full_i;
  assign in_ready_o = !in_valid_q || !res_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q  <= in_byte_i;
      start_q <= in_start_i;
    end
  end

  // Byte decode and next state
  always_comb begin
    slot_e    = start_q ? 16'd1 : slot_q;
    phase_e_v = start_q ? PhTag : phase_q;
    left_e    = start_q ? 3'd0 : left_q;
    skip_e    = start_q ? 16'd0 : skip_q;
    pos_e     = start_q ? cfg_i.base_offset : pos_q;
    halt_e    = start_q ? 1'b0 : halt_q;

    slot_d   = slot_e;
    tag_d    = tag_q;
    phase_d  = phase_e_v;
    left_d   = left_e;
    acc_d    = acc_q;
    skip_d   = skip_e;
    pos_d    = pos_e + 32'd1;
    halt_d   = halt_e;
    hit      = 1'b0;
    fin      = 1'b0;
    fin_step = 16'd1;
    res      = '0;

    if (!halt_e) begin
      unique case (phase_e_v)
        PhTag: begin
          if (slot_e < cfg_i.pool_count) begin
            tag_d = byte_q[3:0];
            acc_d = '0;
            if (byte_q == TagClass || byte_q == TagString) begin
              left_d  = ShortOperandLen;
              phase_d = PhOper;
            end else if (byte_q == TagInteger || byte_q == TagFloat ||
                         byte_q == TagFieldRef || byte_q == TagMethRef ||
                         byte_q == TagIfMethRef || byte_q == TagNameType) begin
              left_d  = WordOperandLen;
              phase_d = PhOper;
            end else if (byte_q == TagLong || byte_q == TagDouble) begin
              // a two-slot entry must fit below the pool count
              if (({1'b0, slot_e} + 17'd1) >= {1'b0, cfg_i.pool_count}) begin
                hit              = 1'b1;
                res.slot_index   = slot_e;
                res.entry_tag    = byte_q[3:0];
                res.status       = StWideOvf;
                halt_d           = 1'b1;
              end else begin
                left_d  = WordOperandLen;
                phase_d = PhWideHi;
              end
            end else if (byte_q == TagUtf8) begin
              acc_d   = pos_e + 32'd1;
              skip_d  = '0;
              left_d  = ShortOperandLen;
              phase_d = PhUlen;
            end else begin
              hit              = 1'b1;
              res.slot_index   = slot_e;
              res.entry_tag    = byte_q[3:0];
              res.entry_value  = {24'd0, byte_q};
              res.status       = StUnknownTag;
              halt_d           = 1'b1;
            end
          end
        end
        PhOper, PhWideHi, PhWideLo: begin
          acc_d  = {acc_q[23:0], byte_q};
          left_d = left_e - 3'd1;
          if (left_d == 3'd0) begin
            if (phase_e_v == PhOper) begin
              fin = 1'b1;
            end else if (phase_e_v == PhWideHi) begin
              // high word goes to the upper slot of the pair
              hit             = 1'b1;
              res.slot_index  = slot_e + 16'd1;
              res.entry_value = acc_d;
              res.status      = StOk;
              acc_d           = '0;
              left_d          = WordOperandLen;
              phase_d         = PhWideLo;
            end else begin
              fin      = 1'b1;
              fin_step = 16'd2;
            end
          end
        end
        PhUlen: begin
          skip_d = {skip_e[7:0], byte_q};
          left_d = left_e - 3'd1;
          if (left_d == 3'd0) begin
            if (skip_d == 16'd0) begin
              fin = 1'b1;
            end else begin
              phase_d = PhUskip;
            end
          end
        end
        default: begin
          skip_d = skip_e - 16'd1;
          if (skip_d == 16'd0) begin
            fin = 1'b1;
          end
        end
      endcase

      // Slot completes: report it and move to the next tag
      if (fin) begin
        hit             = 1'b1;
        res.slot_index  = slot_e;
        res.entry_tag   = tag_d;
        res.entry_value = acc_d;
        res.status      = StOk;
        slot_d          = slot_e + fin_step;
        res.last_entry  = slot_d >= cfg_i.pool_count;
        phase_d         = PhTag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= 16'd1;
      tag_q   <= '0;
      phase_q <= PhTag;
      left_q  <= '0;
      acc_q   <= '0;
      skip_q  <= '0;
      pos_q   <= BaseOffsetReset;
      halt_q  <= 1'b0;
    end else if (advance) begin
      slot_q  <= slot_d;
      tag_q   <= tag_d;
      phase_q <= phase_d;
      left_q  <= left_d;
      acc_q   <= acc_d;
      skip_q  <= skip_d;
      pos_q   <= pos_d;
      halt_q  <= halt_d;
    end
  end

  assign res_valid_o = advance && hit;
  assign res_o       = res;

endmodule

`default_nettype wire

### rtl/core/ccp_out_fifo.sv
// Two-entry result buffer between the parser and the output channel.
// Depends on ccp_pkg for the result struct.
`default_nettype none

module ccp_out_fifo import ccp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire res_t push_data_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output res_t      out_data_o
);

  res_t       mem_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign full_o      = cnt_q[1];
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = mem_q[rd_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/class_constant_pool_parser.sv
// Class-file constant-pool parser: configuration registers, byte parser
// and result buffer. Depends on ccp_pkg, ccp_parser and ccp_out_fifo.
//
// Usage:
//   s_axis: one constant-pool byte per item; tuser flags the first tag byte
//     of a pool and restarts the parser (slot 1, position = base offset).
//   m_axis: at most one result per byte: slot, tag and 32-bit value in
//     tdata, status in tuser, tlast set on the result that completes the pool.
//   cfg: register 0 is the pool count, register 1 the base offset; the
//     base offset takes effect at the next restart byte. Always ready.
// Datapath: an accepted byte is held in the input register, decoded from
//   there into the result buffer, and its result is offered on m_axis from
//   the buffer. Throughput: one byte per cycle while the result buffer is
//   not full, set by the combinational decode between input register and buffer.
// Stalls: the two-entry result buffer lets the input keep flowing while a
//   result waits; input ready drops only while the buffer is full and a
//   byte is held in the input register.
// Reset: pool count 1, base offset 10, parser at slot 1 expecting a tag,
//   buffer empty. After an unknown tag or an overflowing two-slot entry the
//   parser reports the error once and ignores bytes until the next restart.
`default_nettype none

module class_constant_pool_parser import ccp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // byte stream in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] start_of_pool
  // results out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // [15:0] slot_index, [19:16] entry_tag,
                                           // [51:20] entry_value, [55:52] zero
  output logic             m_axis_tlast,   // last_entry
  output logic [1:0]       m_axis_tuser,   // [1:0] status
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  cfg_t cfg_q;
  logic res_valid;
  res_t res;
  logic full;
  res_t out_res;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pool_count  <= PoolCountReset;
      cfg_q.base_offset <= BaseOffsetReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgPoolCount:  cfg_q.pool_count  <= cfg_data_i[15:0];
        CfgBaseOffset: cfg_q.base_offset <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ccp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_start_i  (s_axis_tuser),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_full_i  (full)
  );

  ccp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  // Pack the result item onto the output channel
  assign m_axis_tdata = {4'd0, out_res.entry_value, out_res.entry_tag, out_res.slot_index};
  assign m_axis_tlast = out_res.last_entry;
  assign m_axis_tuser = out_res.status;

endmodule

`default_nettype wire

### test/class_constant_pool_parser_checker.sv
`timescale 1ns / 100ps
// Checker for class_constant_pool_parser: watches the byte, result and register channels,
// predicts every slot report of the constant-pool scan and compares field by field.
// Depends on ccp_pkg for the tag codes, register indexes, phases and the result type.

module class_constant_pool_parser_checker import ccp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] start_of_pool
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,   // [15:0] slot, [19:16] tag, [51:20] value
  input  logic        m_axis_tlast,   // last_entry
  input  logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);

  // register copies
  logic [15:0] pool_count_q;
  logic [31:0] base_offset_q;

  // scanner state
  logic [15:0] slot_q;
  logic [3:0]  tag_q;
  phase_e      phase_q;
  logic [2:0]  left_q;
  logic [31:0] acc_q;
  logic [15:0] skip_q;
  logic [31:0] pos_q;
  bit          halted_q;

  res_t        slot_reports_q[$];
  res_t        seen_r;
  res_t        want_r;
  int          mismatches;

  function automatic res_t make_report(input logic [15:0] slot, input logic [3:0] tag,
                                       input logic [31:0] value, input logic last,
                                       input status_e st);
    res_t r;
    r.slot_index  = slot;
    r.entry_tag   = tag;
    r.entry_value = value;
    r.last_entry  = last;
    r.status      = st;
    return r;
  endfunction

  // report the slot just read and move on by one or two slots
  function automatic void close_slot(input logic [15:0] steps);
    res_t r;
    r = make_report(slot_q, tag_q, acc_q, 1'b0, StOk);
    slot_q = slot_q + steps;
    r.last_entry = (slot_q >= pool_count_q);
    phase_q = PhTag;
    slot_reports_q.push_back(r);
  endfunction

  // one pool byte through the scanner
  function automatic void scan_pool_byte(input logic [7:0] b, input logic sop);
    logic [31:0] pos;
    if (sop) begin
      halted_q = 1'b0;
      slot_q   = 16'd1;
      phase_q  = PhTag;
      left_q   = '0;
      skip_q   = '0;
      pos_q    = base_offset_q;
    end
    pos   = pos_q;
    pos_q = pos_q + 32'd1;
    if (!halted_q) begin
      case (phase_q)
        PhTag: begin
          // tags past the end of the pool are dropped
          if (slot_q < pool_count_q) begin
            tag_q = b[3:0];
            acc_q = '0;
            if (b == TagClass || b == TagString) begin
              left_q  = ShortOperandLen;
              phase_q = PhOper;
            end else if (b == TagInteger || b == TagFloat ||
                         (b >= TagFieldRef && b <= TagNameType)) begin
              left_q  = WordOperandLen;
              phase_q = PhOper;
            end else if (b == TagLong || b == TagDouble) begin
              if ({1'b0, slot_q} + 17'd1 >= {1'b0, pool_count_q}) begin
                slot_reports_q.push_back(make_report(slot_q, b[3:0], '0, 1'b0, StWideOvf));
                halted_q = 1'b1;
              end else begin
                left_q  = WordOperandLen;
                phase_q = PhWideHi;
              end
            end else if (b == TagUtf8) begin
              acc_q   = pos + 32'd1;
              skip_q  = '0;
              left_q  = ShortOperandLen;
              phase_q = PhUlen;
            end else begin
              slot_reports_q.push_back(make_report(slot_q, b[3:0], {24'd0, b}, 1'b0,
                                                   StUnknownTag));
              halted_q = 1'b1;
            end
          end
        end
        PhOper, PhWideHi, PhWideLo: begin
          acc_q  = {acc_q[23:0], b};
          left_q = left_q - 3'd1;
          if (left_q == 3'd0) begin
            if (phase_q == PhOper) begin
              close_slot(16'd1);
            end else if (phase_q == PhWideHi) begin
              // high word belongs to the second slot, reported with tag 0
              slot_reports_q.push_back(make_report(slot_q + 16'd1, 4'd0, acc_q, 1'b0, StOk));
              acc_q   = '0;
              left_q  = WordOperandLen;
              phase_q = PhWideLo;
            end else begin
              close_slot(16'd2);
            end
          end
        end
        PhUlen: begin
          skip_q = {skip_q[7:0], b};
          left_q = left_q - 3'd1;
          if (left_q == 3'd0) begin
            if (skip_q == 16'd0) close_slot(16'd1);
            else phase_q = PhUskip;
          end
        end
        default: begin
          skip_q = skip_q - 16'd1;
          if (skip_q == 16'd0) close_slot(16'd1);
        end
      endcase
    end
  endfunction

  // results are checked before the byte of the same edge is scanned
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_count_q  = PoolCountReset;
      base_offset_q = BaseOffsetReset;
      slot_q        = 16'd1;
      tag_q         = '0;
      phase_q       = PhTag;
      left_q        = '0;
      acc_q         = '0;
      skip_q        = '0;
      pos_q         = BaseOffsetReset;
      halted_q      = 1'b0;
      mismatches    = 0;
      slot_reports_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_r = make_report(m_axis_tdata[15:0], m_axis_tdata[19:16], m_axis_tdata[51:20],
                             m_axis_tlast, status_e'(m_axis_tuser));
        if (slot_reports_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected slot report: slot %0d tag %0d value %h last %0b st %0d",
                     $time, seen_r.slot_index, seen_r.entry_tag, seen_r.entry_value,
                     seen_r.last_entry, seen_r.status);
        end else begin
          want_r = slot_reports_q.pop_front();
          if (seen_r.slot_index !== want_r.slot_index || seen_r.entry_tag !== want_r.entry_tag ||
              seen_r.entry_value !== want_r.entry_value ||
              seen_r.last_entry !== want_r.last_entry || seen_r.status !== want_r.status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: slot report mismatch", $time);
              $display("  expected slot %0d tag %0d value %h last %0b st %0d",
                       want_r.slot_index, want_r.entry_tag, want_r.entry_value,
                       want_r.last_entry, want_r.status);
              $display("  actual   slot %0d tag %0d value %h last %0b st %0d",
                       seen_r.slot_index, seen_r.entry_tag, seen_r.entry_value,
                       seen_r.last_entry, seen_r.status);
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgPoolCount) pool_count_q = cfg_data_i[15:0];
        else base_offset_q = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) scan_pool_byte(s_axis_tdata, s_axis_tuser);
    end
    errors_o  = mismatches;
    pending_o = slot_reports_q.size();
  end

endmodule

### test/class_constant_pool_parser_tb.sv
`timescale 1ns / 100ps
// Testbench top for class_constant_pool_parser: drives pool byte streams, result stalls
// and register writes, and gives the verdict. Depends on ccp_pkg and the checker module.

module class_constant_pool_parser_tb;
  import ccp_pkg::*;

  localparam int ClkPeriod   = 12;
  localparam int DrainCycles = 4;        // input register plus result buffer, with margin
  localparam int LimitNs     = 6_000_000;
  localparam int RandomBytes = 650;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;             // [7:0] data_byte
  logic        s_axis_tuser;             // [0] start_of_pool
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;             // [15:0] slot, [19:16] tag, [51:20] value
  logic        m_axis_tlast;             // last_entry
  logic [1:0]  m_axis_tuser;             // [1:0] status
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [31:0] cfg_data_i;

  int          errors;
  int          pending;
  int          send_idle_pct = 30;
  int          recv_idle_pct = 30;
  int          bytes_sent;
  logic [15:0] pool_count_set;
  logic [31:0] base_offset_set;

  class_constant_pool_parser uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  class_constant_pool_parser_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // result-side stalls
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #(LimitNs);
    $display("tb: failure");
    $finish;
  end

  // one byte on the stream, with random gaps ahead of it
  task automatic send_byte(input logic [7:0] b, input logic sop);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tuser  = sop;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  // hold the stream until every predicted report has arrived and the pipe is empty
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [7:0] random_known_tag();
    case ($urandom_range(10))
      0: return TagUtf8;
      1: return TagInteger;
      2: return TagFloat;
      3: return TagLong;
      4: return TagDouble;
      5: return TagClass;
      6: return TagString;
      7: return TagFieldRef;
      8: return TagMethRef;
      9: return TagIfMethRef;
      default: return TagNameType;
    endcase
  endfunction

  // a whole entry: tag, then operands; fill < 0 gives random operand bytes
  task automatic send_entry(input logic [7:0] tag, input logic sop, input int ulen,
                            input int fill);
    int nbytes;
    logic [7:0] b;
    send_byte(tag, sop);
    if (tag == TagUtf8) begin
      send_byte(ulen[15:8], 1'b0);
      send_byte(ulen[7:0], 1'b0);
      nbytes = ulen;
    end else if (tag == TagClass || tag == TagString) begin
      nbytes = 2;
    end else if (tag == TagLong || tag == TagDouble) begin
      nbytes = 8;
    end else begin
      nbytes = 4;
    end
    repeat (nbytes) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      send_byte(b, 1'b0);
    end
  endtask

  // one pool under the current registers: mostly well-formed entries, some broken
  task automatic run_pool();
    int slots_left;
    int entries;
    int pick;
    int ulen;
    logic [7:0] tag;
    logic sop;
    slots_left = int'(pool_count_set) - 1;
    entries    = $urandom_range(1, 14);
    sop        = 1'b1;
    if (slots_left == 0) begin
      // empty pool: tags are dropped
      send_byte(random_known_tag(), 1'b1);
      send_byte(8'($urandom), 1'b0);
      return;
    end
    while (entries > 0 && slots_left > 0) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        // unknown tag halts the parser; trailing bytes are dropped
        case ($urandom_range(2))
          0: tag = 8'd0;
          1: tag = 8'd2;
          default: tag = 8'($urandom_range(13, 255));
        endcase
        send_byte(tag, sop);
        repeat ($urandom_range(3)) send_byte(8'($urandom), 1'b0);
        return;
      end
      tag = random_known_tag();
      if (pick < 8) begin
        // entry cut short: the next pool restarts mid-entry
        send_byte(tag, sop);
        repeat ($urandom_range(2)) send_byte(8'($urandom), 1'b0);
        return;
      end
      pick = $urandom_range(49);
      if (pick == 0) ulen = $urandom_range(256, 259);
      else if (pick < 12) ulen = 0;
      else ulen = $urandom_range(1, 5);
      send_entry(tag, sop, ulen, -1);
      if (tag == TagLong || tag == TagDouble) begin
        if (slots_left < 2) return;     // overflowed the pool, parser halted
        slots_left -= 2;
      end else begin
        slots_left -= 1;
      end
      sop = 1'b0;
      entries--;
      if ($urandom_range(9) == 0) wait_drained();
    end
    // bytes after a complete pool are dropped
    if (slots_left == 0) repeat ($urandom_range(2)) send_byte(8'($urandom), 1'b0);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CfgPoolCount;
    cfg_data_i    = '0;
    bytes_sent    = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset registers give an empty pool: the tag is dropped
    send_byte(TagClass, 1'b1);
    send_byte(8'h5A, 1'b0);
    wait_drained();

    // UTF8 offsets across the 32-bit wrap, then a wide entry on the last slot
    write_reg(CfgPoolCount, 32'd4);
    write_reg(CfgBaseOffset, 32'hFFFF_FFFE);
    send_entry(TagUtf8, 1'b1, 0, -1);
    send_entry(TagUtf8, 1'b0, 1, 8'hFF);
    send_entry(TagDouble, 1'b0, 0, -1);   // halted: its operand bytes are dropped
    // unknown tags at both ends of the byte range
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    wait_drained();

    // restart mid-entry, then a wide entry that completes the pool
    write_reg(CfgPoolCount, 32'd3);
    write_reg(CfgBaseOffset, 32'd0);
    send_byte(TagInteger, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_entry(TagLong, 1'b1, 0, 8'hFF);
    send_byte(TagInteger, 1'b0);          // pool complete: dropped
    wait_drained();

    // largest pool and offset, all-zero and all-one operands
    write_reg(CfgPoolCount, 32'h0000_FFFF);
    write_reg(CfgBaseOffset, 32'hFFFF_FFFF);
    send_entry(TagInteger, 1'b1, 0, 8'h00);
    send_entry(TagFieldRef, 1'b0, 0, 8'hFF);

    // random pools
    bytes_sent = 0;
    while (bytes_sent < RandomBytes) begin
      // long stretch with no idling on either side
      if (bytes_sent >= 250 && bytes_sent < 400) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = 30;
        recv_idle_pct = 30;
      end
      wait_drained();
      case ($urandom_range(9))
        0: pool_count_set = 16'hFFFF;
        1: pool_count_set = 16'd1;
        default: pool_count_set = 16'($urandom_range(2, 12));
      endcase
      case ($urandom_range(7))
        0: base_offset_set = 32'd0;
        1: base_offset_set = 32'hFFFF_FFFF;
        default: base_offset_set = $urandom();
      endcase
      write_reg(CfgPoolCount, {16'd0, pool_count_set});
      write_reg(CfgBaseOffset, base_offset_set);
      run_pool();
    end

    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (2 * DrainCycles) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### class_constant_pool_parser.f
rtl/core/ccp_pkg.sv
rtl/core/ccp_parser.sv
rtl/core/ccp_out_fifo.sv
rtl/core/class_constant_pool_parser.sv
test/class_constant_pool_parser_checker.sv
test/class_constant_pool_parser_tb.sv
